// File: design/e820m_pkg.sv
// ----------------------------------------------------------------------------
// e820m_pkg
// Shared types, codes and the memory type lookup for the region merger.
// ----------------------------------------------------------------------------
package e820m_pkg;

  localparam int unsigned PageShift = 12;

  // Result action codes
  localparam logic [1:0] ACT_SKIP  = 2'd0;
  localparam logic [1:0] ACT_MERGE = 2'd1;
  localparam logic [1:0] ACT_NEW   = 2'd2;
  localparam logic [1:0] ACT_FULL  = 2'd3;

  // E820 entry types
  localparam logic [2:0] MEM_NONE     = 3'd0;
  localparam logic [2:0] MEM_RAM      = 3'd1;
  localparam logic [2:0] MEM_RESERVED = 3'd2;
  localparam logic [2:0] MEM_ACPI     = 3'd3;
  localparam logic [2:0] MEM_NVS      = 3'd4;
  localparam logic [2:0] MEM_UNUSABLE = 3'd5;

  // UEFI memory type codes, standard numbering
  localparam logic [31:0] EFI_RESERVED      = 32'd0;
  localparam logic [31:0] EFI_LOADER_CODE   = 32'd1;
  localparam logic [31:0] EFI_LOADER_DATA   = 32'd2;
  localparam logic [31:0] EFI_BS_CODE       = 32'd3;
  localparam logic [31:0] EFI_BS_DATA       = 32'd4;
  localparam logic [31:0] EFI_RT_CODE       = 32'd5;
  localparam logic [31:0] EFI_RT_DATA       = 32'd6;
  localparam logic [31:0] EFI_CONVENTIONAL  = 32'd7;
  localparam logic [31:0] EFI_UNUSABLE      = 32'd8;
  localparam logic [31:0] EFI_ACPI_RECLAIM  = 32'd9;
  localparam logic [31:0] EFI_ACPI_NVS      = 32'd10;
  localparam logic [31:0] EFI_MMIO          = 32'd11;
  localparam logic [31:0] EFI_MMIO_PORT     = 32'd12;
  localparam logic [31:0] EFI_PAL_CODE      = 32'd13;

  typedef struct packed {
    logic        start_of_map;
    logic [31:0] efi_type;
    logic [63:0] region_start;
    logic [51:0] page_count;
    logic        last_region;
  } e820m_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  entry_index;
    logic [63:0] entry_address;
    logic [63:0] entry_size;
    logic [2:0]  entry_type;
    logic [7:0]  entry_count;
    logic        done_res;
  } e820m_out_t;

  typedef struct packed {
    logic       have_previous;
    logic       table_full;
    logic [7:0] stored_count;
  } e820m_status_t;

  function automatic logic [2:0] map_type(input logic [31:0] code);
    logic [2:0] t;
    case (code)
      EFI_RESERVED, EFI_RT_CODE, EFI_RT_DATA,
      EFI_MMIO, EFI_MMIO_PORT, EFI_PAL_CODE:        t = MEM_RESERVED;
      EFI_UNUSABLE:                                t = MEM_UNUSABLE;
      EFI_ACPI_RECLAIM:                            t = MEM_ACPI;
      EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BS_CODE,
      EFI_BS_DATA, EFI_CONVENTIONAL:               t = MEM_RAM;
      EFI_ACPI_NVS:                                t = MEM_NVS;
      default:                                     t = MEM_NONE;
    endcase
    return t;
  endfunction

endpackage

// File: design/e820m_chan_if.sv
// ----------------------------------------------------------------------------
// e820m channel interfaces
// Valid/ready channels for descriptors in and table results out.
// ----------------------------------------------------------------------------
interface e820m_in_if;
  import e820m_pkg::*;

  logic      valid;
  logic      ready;
  e820m_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface e820m_out_if;
  import e820m_pkg::*;

  logic       valid;
  logic       ready;
  e820m_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/e820m_in_reg.sv
// ----------------------------------------------------------------------------
// e820m_in_reg
// Input register stage: holds one descriptor until the merge stage takes it.
// ----------------------------------------------------------------------------
module e820m_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  e820m_pkg::e820m_in_t in_data_i,
  input  logic                 take_i,
  output logic                 valid_o,
  output e820m_pkg::e820m_in_t data_o
);
  import e820m_pkg::*;

  logic      valid_q, valid_d;
  e820m_in_t data_q;
  logic      load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/e820m_merge.sv
// ----------------------------------------------------------------------------
// e820m_merge
// Previous-entry state and the per-descriptor merge/append decision.
// ----------------------------------------------------------------------------
module e820m_merge #(
  parameter int unsigned MAX_ENTRIES = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  e820m_pkg::e820m_in_t     item_i,
  output e820m_pkg::e820m_out_t    result_o,
  output e820m_pkg::e820m_status_t status_o
);
  import e820m_pkg::*;

  localparam int unsigned CapInt   = (MAX_ENTRIES > 255) ? 255 : MAX_ENTRIES;
  localparam logic [7:0]  Capacity = 8'(CapInt);

  logic        have_q, have_d, have_b;
  logic [2:0]  ptype_q, ptype_d, ptype_b;
  logic [63:0] paddr_q, paddr_d, paddr_b;
  logic [63:0] psize_q, psize_d, psize_b;
  logic [7:0]  count_q, count_d, count_b;
  logic        full_q, full_d, full_b;

  logic [2:0]  etype;
  logic [63:0] bytes;
  logic [63:0] grown;
  logic        contiguous;

  // Start of map clears the state seen by this descriptor
  always_comb begin
    have_b  = item_i.start_of_map ? 1'b0  : have_q;
    ptype_b = item_i.start_of_map ? MEM_NONE : ptype_q;
    paddr_b = item_i.start_of_map ? 64'd0 : paddr_q;
    psize_b = item_i.start_of_map ? 64'd0 : psize_q;
    count_b = item_i.start_of_map ? 8'd0  : count_q;
    full_b  = item_i.start_of_map ? 1'b0  : full_q;
  end

  assign etype      = map_type(item_i.efi_type);
  assign bytes      = {item_i.page_count, {PageShift{1'b0}}};
  assign grown      = psize_b + bytes;
  assign contiguous = have_b && (ptype_b == etype) &&
                      ((paddr_b + psize_b) == item_i.region_start);

  always_comb begin
    have_d  = have_b;
    ptype_d = ptype_b;
    paddr_d = paddr_b;
    psize_d = psize_b;
    count_d = count_b;
    full_d  = full_b;

    result_o               = '0;
    result_o.done_res      = item_i.last_region;

    if (full_b) begin
      result_o.action = ACT_FULL;
    end else if (etype == MEM_NONE) begin
      result_o.action = ACT_SKIP;
    end else if (contiguous) begin
      psize_d                = grown;
      result_o.action        = ACT_MERGE;
      result_o.entry_index   = 7'(count_b - 8'd1);
      result_o.entry_address = paddr_b;
      result_o.entry_size    = grown;
      result_o.entry_type    = etype;
    end else if (count_b >= Capacity) begin
      full_d          = 1'b1;
      result_o.action = ACT_FULL;
    end else begin
      have_d                 = 1'b1;
      ptype_d                = etype;
      paddr_d                = item_i.region_start;
      psize_d                = bytes;
      count_d                = count_b + 8'd1;
      result_o.action        = ACT_NEW;
      result_o.entry_index   = count_b[6:0];
      result_o.entry_address = item_i.region_start;
      result_o.entry_size    = bytes;
      result_o.entry_type    = etype;
    end

    result_o.entry_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      ptype_q <= MEM_NONE;
      paddr_q <= 64'd0;
      psize_q <= 64'd0;
      count_q <= 8'd0;
      full_q  <= 1'b0;
    end else if (advance_i) begin
      have_q  <= have_d;
      ptype_q <= ptype_d;
      paddr_q <= paddr_d;
      psize_q <= psize_d;
      count_q <= count_d;
      full_q  <= full_d;
    end
  end

  assign status_o.have_previous = have_q;
  assign status_o.table_full    = full_q;
  assign status_o.stored_count  = count_q;

endmodule

// File: design/efi_to_e820_region_merger.sv
// ----------------------------------------------------------------------------
// efi_to_e820_region_merger
// Converts a stream of UEFI memory descriptors into E820 table writes,
// merging contiguous regions of the same type.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                   | transfer when
//  --------+-----+-------------------------------------------+--------------
//  in_i    | in  | start_of_map, efi_type, region_start,     | valid & ready
//          |     | page_count, last_region                   |
//  out_o   | out | action, entry_index, entry_address,       | valid & ready
//          |     | entry_size, entry_type, entry_count,      |
//          |     | done_res                                  |
//
//  One descriptor per cycle sustained while out_o is not stalled. The input
//  transfer loads the input register; the result register loads from it on
//  advance and offers the result on out_o. The previous-entry state
//  updates in the same cycle the result register loads, so back-to-back
//  descriptors see each other's effect.
//  Reset clears the valid bits, the previous entry, the count and the full
//  flag. A stalled output holds the result register and, once the input
//  register is also occupied, drops in_i.ready.
//
module efi_to_e820_region_merger #(
  parameter int unsigned MAX_ENTRIES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  e820m_in_if.sink           in_i,
  e820m_out_if.source        out_o
);
  import e820m_pkg::*;

  logic          stage_valid;
  e820m_in_t     stage_item;
  logic          advance;
  e820m_out_t    result;
  e820m_status_t status;

  logic          out_valid_q, out_valid_d;
  e820m_out_t    out_q;

  // Advance the held descriptor when the result register is free or draining
  assign advance = stage_valid && (!out_valid_q || out_o.ready);

  e820m_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_data_i  (in_i.data),
    .take_i     (advance),
    .valid_o    (stage_valid),
    .data_o     (stage_item)
  );

  e820m_merge #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_item),
    .result_o  (result),
    .status_o  (status)
  );

  // Result register: load on advance, release on an output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // A new or grown entry always refers to the last entry of the table
  a_index_tracks_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.action == ACT_NEW || out_q.action == ACT_MERGE))
      |-> (out_q.entry_index == 7'(out_q.entry_count - 8'd1)))
    else $error("entry index does not match entry count");

  // Skipped and full results carry no entry
  a_empty_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.action == ACT_SKIP || out_q.action == ACT_FULL))
      |-> (out_q.entry_address == 64'd0 && out_q.entry_size == 64'd0 &&
           out_q.entry_type == MEM_NONE))
    else $error("skipped or full result carries entry data");

  // A full result leaves the sticky flag set behind it
  a_full_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result.action == ACT_FULL) |=> status.table_full)
    else $error("full result without sticky full flag");

endmodule
